// ----- rtl/thb_pkg.sv -----
// Shared types and constants for the timestamped history buffer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package thb_pkg;

    localparam int STAMP_W   = 48;
    localparam int PAYLOAD_W = 64;
    localparam int KEEP_W    = 48;
    localparam int TOL_W     = 10;
    localparam int REG_IDX_W = 1;
    localparam int REG_DATA_W = 48;

    localparam logic [KEEP_W-1:0] KEEP_WINDOW_RESET = 48'd1000000000;
    localparam logic [TOL_W-1:0]  STAMP_TOL_RESET   = 10'd1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_KEEP_WINDOW = 1'b0,
        REG_STAMP_TOL   = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_PRUNE  = 2'd1,
        OP_FIND   = 2'd2,
        OP_ERASE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_STALE     = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_WRITE,
        ST_DONE
    } thb_state_t;

endpackage

`default_nettype wire

// ----- rtl/thb_ring_mem.sv -----
// Entry storage of the history buffer: stamp and payload per slot.
// One write port, one read port with registered read data; uses thb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module thb_ring_mem
    import thb_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
)
(
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_W-1:0]    wr_addr,
    input  wire logic [STAMP_W-1:0]   wr_stamp,
    input  wire logic [PAYLOAD_W-1:0] wr_payload,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_W-1:0]    rd_addr,
    output logic      [STAMP_W-1:0]   rd_stamp,
    output logic      [PAYLOAD_W-1:0] rd_payload
);

    logic [STAMP_W-1:0]   stamp_mem   [DEPTH];
    logic [PAYLOAD_W-1:0] payload_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stamp_mem[wr_addr]   <= wr_stamp;
            payload_mem[wr_addr] <= wr_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_stamp   <= stamp_mem[rd_addr];
            rd_payload <= payload_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/timestamped_history_buffer.sv -----
// Top level of the timestamped history buffer: control sequencer and registers.
// Depends on thb_pkg and thb_ring_mem.
//
// Command channel: drive operation, stamp and payload and raise start; the
// transaction is taken at a clock edge where start is high and busy is low.
// Result channel: done is high for exactly one cycle, with status, found_index,
// stamp_gap, found_payload and entry_count valid in that cycle. The receiver
// cannot stall; done marks the result valid only in that cycle.
// Configuration: reg_we with reg_index and reg_wdata writes keep_window
// (index 0) or stamp_tolerance (index 1); write only while busy is low.
// Sequencing: each entry visited passes through ST_READ and then ST_EVAL,
// since the ring memory returns registered read data. An insert that is not
// stale then goes through ST_WRITE, and every transaction ends in ST_DONE.
// On an empty ring an insert goes straight to ST_WRITE and any other
// operation to ST_DONE. The next command is taken in ST_IDLE, which
// follows ST_DONE.
// Reset: the ring is empty, the configuration registers take their reset values, and the
// memory needs no clearing because only held entries are read.
`timescale 1ns / 1ps
`default_nettype none

module timestamped_history_buffer
    import thb_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   operation,
    input  wire logic [STAMP_W-1:0]           stamp,
    input  wire logic [PAYLOAD_W-1:0]         payload,
    input  wire logic                         reg_we,
    input  wire logic [REG_IDX_W-1:0]         reg_index,
    input  wire logic [REG_DATA_W-1:0]        reg_wdata,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [$clog2(DEPTH)-1:0]          found_index,
    output logic [STAMP_W-1:0]                stamp_gap,
    output logic [PAYLOAD_W-1:0]              found_payload,
    output logic [$clog2(DEPTH+1)-1:0]        entry_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 2;
    localparam int EXT_W = STAMP_W + 1;

    thb_state_t             state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [STAMP_W-1:0]     stamp_reg, stamp_next;
    logic [PAYLOAD_W-1:0]   payload_reg, payload_next;
    logic [EXT_W-1:0]       st_hi_reg, st_hi_next;
    logic [EXT_W-1:0]       st_lo_reg, st_lo_next;
    logic                   first_reg, first_next;
    logic [CNT_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [PTR_W-1:0]       oldest_reg, oldest_next;
    logic [KEEP_W-1:0]      keep_window_reg, keep_window_next;
    logic [TOL_W-1:0]       tol_reg, tol_next;
    status_t                status_reg, status_next;
    logic [PTR_W-1:0]       fidx_reg, fidx_next;
    logic [STAMP_W-1:0]     aerr_reg, aerr_next;
    logic [PAYLOAD_W-1:0]   fpl_reg, fpl_next;

    logic                   mem_wr_en;
    logic                   mem_rd_en;
    logic [PTR_W-1:0]       slot;
    logic [CNT_W-1:0]       offset;
    logic [SUM_W-1:0]       slot_sum;
    logic [STAMP_W-1:0]     rd_stamp;
    logic [PAYLOAD_W-1:0]   rd_payload;
    logic                   is_later;
    logic                   is_within;
    logic                   is_aged;

    thb_ring_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (PTR_W)
    ) u_mem (
        .clk        (clk),
        .wr_en      (mem_wr_en),
        .wr_addr    (slot),
        .wr_stamp   (stamp_reg),
        .wr_payload (payload_reg),
        .rd_en      (mem_rd_en),
        .rd_addr    (slot),
        .rd_stamp   (rd_stamp),
        .rd_payload (rd_payload)
    );

    // Ring slot of the entry at offset from the oldest; sum stays below 2*DEPTH whenever the slot is read or written.
    always_comb
    begin
        if (op_reg == OP_PRUNE)
            offset = '0;
        else if (state_reg == ST_WRITE)
            offset = pos_reg;
        else
            offset = pos_reg - CNT_W'(1);
        slot_sum = SUM_W'(oldest_reg) + SUM_W'(offset);
        if (slot_sum >= SUM_W'(DEPTH))
            slot = PTR_W'(slot_sum - SUM_W'(DEPTH));
        else
            slot = PTR_W'(slot_sum);
    end

    // Stamp compares against the read entry.
    assign is_later  = {1'b0, rd_stamp} > st_hi_reg;
    assign is_within = ({1'b0, rd_stamp} <= st_hi_reg) &&
                       (st_lo_reg[STAMP_W] || (rd_stamp >= st_lo_reg[STAMP_W-1:0]));
    assign is_aged   = {1'b0, stamp_reg} > ({1'b0, rd_stamp} + {1'b0, keep_window_reg});

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        stamp_next       = stamp_reg;
        payload_next     = payload_reg;
        st_hi_next       = st_hi_reg;
        st_lo_next       = st_lo_reg;
        first_next       = first_reg;
        pos_next         = pos_reg;
        count_next       = count_reg;
        oldest_next      = oldest_reg;
        keep_window_next = keep_window_reg;
        tol_next         = tol_reg;
        status_next      = status_reg;
        fidx_next        = fidx_reg;
        aerr_next        = aerr_reg;
        fpl_next         = fpl_reg;
        mem_wr_en        = 1'b0;
        mem_rd_en        = 1'b0;

        if (reg_we)
        begin
            case (reg_index_t'(reg_index))
                REG_KEEP_WINDOW: keep_window_next = reg_wdata[KEEP_W-1:0];
                REG_STAMP_TOL:   tol_next = reg_wdata[TOL_W-1:0];
                default:         tol_next = tol_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next      = op_t'(operation);
                    stamp_next   = stamp;
                    payload_next = payload;
                    st_hi_next   = {1'b0, stamp} + EXT_W'(tol_reg);
                    st_lo_next   = {1'b0, stamp} - EXT_W'(tol_reg);
                    first_next   = 1'b1;
                    pos_next     = count_reg;
                    status_next  = STATUS_OK;
                    fidx_next    = '0;
                    aerr_next    = '0;
                    fpl_next     = '0;
                    if (count_reg == '0)
                    begin
                        if (op_t'(operation) == OP_INSERT)
                            state_next = ST_WRITE;
                        else
                        begin
                            if (op_t'(operation) == OP_FIND)
                                status_next = STATUS_NOT_FOUND;
                            state_next = ST_DONE;
                        end
                    end
                    else
                        state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                mem_rd_en  = 1'b1;
                state_next = ST_EVAL;
            end

            ST_EVAL:
            begin
                first_next = 1'b0;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (first_reg && is_later)
                        begin
                            status_next = STATUS_STALE;
                            state_next  = ST_DONE;
                        end
                        else if (is_within)
                        begin
                            // drop this newest entry from the kept span
                            pos_next = pos_reg - CNT_W'(1);
                            if (pos_reg == CNT_W'(1))
                                state_next = ST_WRITE;
                            else
                                state_next = ST_READ;
                        end
                        else
                            state_next = ST_WRITE;
                    end
                    OP_PRUNE:
                    begin
                        if (is_aged)
                        begin
                            oldest_next = (oldest_reg == PTR_W'(DEPTH - 1)) ?
                                          '0 : oldest_reg + PTR_W'(1);
                            count_next  = count_reg - CNT_W'(1);
                            if (count_reg == CNT_W'(1))
                                state_next = ST_DONE;
                            else
                                state_next = ST_READ;
                        end
                        else
                            state_next = ST_DONE;
                    end
                    OP_FIND:
                    begin
                        if (!is_later)
                        begin
                            fidx_next  = PTR_W'(pos_reg - CNT_W'(1));
                            aerr_next  = (stamp_reg > rd_stamp) ? stamp_reg - rd_stamp : '0;
                            fpl_next   = rd_payload;
                            state_next = ST_DONE;
                        end
                        else if (pos_reg == CNT_W'(1))
                        begin
                            status_next = STATUS_NOT_FOUND;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            pos_next   = pos_reg - CNT_W'(1);
                            state_next = ST_READ;
                        end
                    end
                    OP_ERASE:
                    begin
                        if (is_later)
                        begin
                            pos_next   = pos_reg - CNT_W'(1);
                            count_next = pos_reg - CNT_W'(1);
                            if (pos_reg == CNT_W'(1))
                                state_next = ST_DONE;
                            else
                                state_next = ST_READ;
                        end
                        else
                            state_next = ST_DONE;
                    end
                    default:
                        state_next = ST_DONE;
                endcase
            end

            ST_WRITE:
            begin
                // a ring still full after dropping near-equal entries rejects
                if (pos_reg == CNT_W'(DEPTH))
                    status_next = STATUS_FULL;
                else
                begin
                    mem_wr_en  = 1'b1;
                    count_next = pos_reg + CNT_W'(1);
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (count_reg == '0)
                    oldest_next = '0;
                state_next = ST_IDLE;
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            oldest_reg      <= '0;
            keep_window_reg <= KEEP_WINDOW_RESET;
            tol_reg         <= STAMP_TOL_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            oldest_reg      <= oldest_next;
            keep_window_reg <= keep_window_next;
            tol_reg         <= tol_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        stamp_reg   <= stamp_next;
        payload_reg <= payload_next;
        st_hi_reg   <= st_hi_next;
        st_lo_reg   <= st_lo_next;
        first_reg   <= first_next;
        pos_reg     <= pos_next;
        status_reg  <= status_next;
        fidx_reg    <= fidx_next;
        aerr_reg    <= aerr_next;
        fpl_reg     <= fpl_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = (state_reg == ST_DONE);
    assign status          = status_reg;
    assign found_index     = fidx_reg;
    assign stamp_gap       = aerr_reg;
    assign found_payload   = fpl_reg;
    assign entry_count     = count_reg;

endmodule

`default_nettype wire

// ----- rtl/thb_checker.sv -----
// Port-level checks for the timestamped history buffer, bound to the top level.
// Depends on thb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module thb_checker
    import thb_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic                         done,
    input wire logic [1:0]                   status,
    input wire logic [$clog2(DEPTH)-1:0]     found_index,
    input wire logic [STAMP_W-1:0]           stamp_gap,
    input wire logic [PAYLOAD_W-1:0]         found_payload,
    input wire logic [$clog2(DEPTH+1)-1:0]   entry_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // an accepted transaction keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // the result strobe lasts one cycle and the block is free after it
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe not a single cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result shown while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (entry_count <= CNT_W'(DEPTH)))
        else $error("entry count exceeds depth");

    // a failed search reports no entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STATUS_NOT_FOUND)) |->
            (found_index == '0 && stamp_gap == '0 && found_payload == '0))
        else $error("not-found result carries entry data");

endmodule

bind timestamped_history_buffer thb_checker #(
    .DEPTH (DEPTH)
) u_thb_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .status          (status),
    .found_index     (found_index),
    .stamp_gap       (stamp_gap),
    .found_payload   (found_payload),
    .entry_count     (entry_count)
);

`default_nettype wire
